>>> rtl/utf8_cjk_text_filter_assert.svh
// assertion macros for the utf-8 cjk text filter
`ifndef UTF8_CJK_TEXT_FILTER_ASSERT_SVH
`define UTF8_CJK_TEXT_FILTER_ASSERT_SVH

// antecedent implies consequent in the same cycle, checked out of reset
`define UCTF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must never hold out of reset
`define UCTF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

>>> rtl/uctf_pkg.sv
// shared types and constants of the utf-8 cjk text filter
`default_nettype none

package uctf_pkg;

  localparam logic [7:0] BYTE_CJK_LO   = 8'hE4;
  localparam logic [7:0] BYTE_CJK_HI   = 8'hE9;
  localparam logic [7:0] BYTE_LEAD_E3  = 8'hE3;
  localparam logic [7:0] BYTE_CONT_80  = 8'h80;
  localparam logic [7:0] BYTE_CN_COMMA = 8'h81;
  localparam logic [7:0] BYTE_CN_STOP  = 8'h82;
  localparam logic [7:0] BYTE_UPPER_LO = 8'h41;
  localparam logic [7:0] BYTE_UPPER_HI = 8'h5A;
  localparam logic [7:0] BYTE_LOWER_LO = 8'h61;
  localparam logic [7:0] BYTE_LOWER_HI = 8'h7A;
  localparam logic [7:0] BYTE_DIGIT_LO = 8'h30;
  localparam logic [7:0] BYTE_DIGIT_HI = 8'h39;
  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] BYTE_PLUS     = 8'h2B;
  localparam logic [7:0] BYTE_MINUS    = 8'h2D;
  localparam logic [7:0] BYTE_SLASH    = 8'h2F;
  localparam logic [7:0] BYTE_STAR     = 8'h2A;
  localparam logic [7:0] BYTE_COMMA    = 8'h2C;
  localparam logic [7:0] BYTE_DOT      = 8'h2E;
  localparam logic [7:0] BYTE_BANG     = 8'h21;
  localparam logic [7:0] MASK_E0       = 8'hE0;
  localparam logic [7:0] MASK_F0       = 8'hF0;
  localparam logic [7:0] MASK_F8       = 8'hF8;
  localparam logic [7:0] LEAD_C0       = 8'hC0;
  localparam logic [7:0] LEAD_F0       = 8'hF0;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CJK  = 4'b0010,
    ST_E3   = 4'b0100,
    ST_SKIP = 4'b1000
  } kind_t;

  // one group of results caused by one input word
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;
    logic       flag_only;
    logic       last;
    logic       chin;
    logic       punc;
  } ent_t;

  function automatic logic passes_plain(input logic [7:0] b);
    logic r;
    r = (b inside {[BYTE_UPPER_LO:BYTE_UPPER_HI], [BYTE_LOWER_LO:BYTE_LOWER_HI],
                   [BYTE_DIGIT_LO:BYTE_DIGIT_HI], BYTE_SPACE, BYTE_PLUS, BYTE_MINUS,
                   BYTE_SLASH, BYTE_STAR});
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/uctf_front.sv
// front end: classifies each input word and builds result groups
`default_nettype none

module uctf_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_last,
  input  wire logic          q_full,
  output logic               push,
  output uctf_pkg::ent_t     push_ent
);

  uctf_pkg::kind_t kind_r, kind_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic [7:0]      held0_r, held0_nxt;
  logic [7:0]      held1_r, held1_nxt;
  logic            chin_r, chin_nxt;
  logic            punc_r, punc_nxt;
  logic            punc_fin;
  logic [1:0]      nb;
  logic [7:0]      eb0;
  logic            keep;
  logic            accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    kind_nxt  = kind_r;
    cnt_nxt   = cnt_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    chin_nxt  = chin_r;
    punc_nxt  = punc_r;
    nb        = 2'd0;
    eb0       = in_byte;
    keep      = 1'b0;
    case (kind_r)
      uctf_pkg::ST_IDLE: begin
        if (in_byte inside {[uctf_pkg::BYTE_CJK_LO:uctf_pkg::BYTE_CJK_HI]}) begin
          kind_nxt  = uctf_pkg::ST_CJK;
          cnt_nxt   = 2'd2;
          held0_nxt = in_byte;
        end else if (uctf_pkg::passes_plain(in_byte)) begin
          nb = 2'd1;
        end else begin
          punc_nxt = 1'b1;
          if (in_byte == uctf_pkg::BYTE_LEAD_E3) begin
            kind_nxt  = uctf_pkg::ST_E3;
            cnt_nxt   = 2'd2;
            held0_nxt = in_byte;
          end else if (in_byte inside {uctf_pkg::BYTE_COMMA, uctf_pkg::BYTE_DOT,
                                       uctf_pkg::BYTE_BANG}) begin
            nb = 2'd1;
          end else if (!in_byte[7]) begin
            kind_nxt = uctf_pkg::ST_IDLE;
          end else if ((in_byte & uctf_pkg::MASK_E0) == uctf_pkg::LEAD_C0) begin
            kind_nxt = uctf_pkg::ST_SKIP;
            cnt_nxt  = 2'd1;
          end else if ((in_byte & uctf_pkg::MASK_F0) == uctf_pkg::MASK_E0) begin
            kind_nxt = uctf_pkg::ST_SKIP;
            cnt_nxt  = 2'd2;
          end else if ((in_byte & uctf_pkg::MASK_F8) == uctf_pkg::LEAD_F0) begin
            kind_nxt = uctf_pkg::ST_SKIP;
            cnt_nxt  = 2'd3;
          end
        end
      end
      uctf_pkg::ST_CJK, uctf_pkg::ST_E3: begin
        if (cnt_r == 2'd2) begin
          held1_nxt = in_byte;
          cnt_nxt   = 2'd1;
        end else begin
          if (kind_r == uctf_pkg::ST_CJK) begin
            keep     = 1'b1;
            chin_nxt = 1'b1;
          end else begin
            keep = (held1_r == uctf_pkg::BYTE_CONT_80) &&
                   (in_byte inside {uctf_pkg::BYTE_CN_COMMA, uctf_pkg::BYTE_CN_STOP});
          end
          if (keep) begin
            nb  = 2'd3;
            eb0 = held0_r;
          end
          kind_nxt = uctf_pkg::ST_IDLE;
          cnt_nxt  = 2'd0;
        end
      end
      uctf_pkg::ST_SKIP: begin
        if (cnt_r <= 2'd1) begin
          kind_nxt = uctf_pkg::ST_IDLE;
          cnt_nxt  = 2'd0;
        end else begin
          cnt_nxt = cnt_r - 2'd1;
        end
      end
      default: begin
        kind_nxt = uctf_pkg::ST_IDLE;
        cnt_nxt  = 2'd0;
      end
    endcase
  end

  // a chinese lead cut short by the final word counts as punctuation
  assign punc_fin = punc_nxt || (kind_nxt == uctf_pkg::ST_CJK);

  always_comb begin
    push_ent.b0        = eb0;
    push_ent.b1        = held1_r;
    push_ent.b2        = in_byte;
    push_ent.cnt       = nb;
    push_ent.flag_only = 1'b0;
    push_ent.last      = in_last;
    push_ent.chin      = chin_nxt;
    push_ent.punc      = punc_fin;
    if (nb == 2'd0) begin
      push_ent.b0        = 8'h00;
      push_ent.cnt       = 2'd1;
      push_ent.flag_only = 1'b1;
    end
  end

  assign push = accept && ((nb != 2'd0) || in_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= uctf_pkg::ST_IDLE;
      cnt_r   <= 2'd0;
      held0_r <= 8'h00;
      held1_r <= 8'h00;
      chin_r  <= 1'b0;
      punc_r  <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        kind_r  <= uctf_pkg::ST_IDLE;
        cnt_r   <= 2'd0;
        held0_r <= 8'h00;
        held1_r <= 8'h00;
        chin_r  <= 1'b0;
        punc_r  <= 1'b0;
      end else begin
        kind_r  <= kind_nxt;
        cnt_r   <= cnt_nxt;
        held0_r <= held0_nxt;
        held1_r <= held1_nxt;
        chin_r  <= chin_nxt;
        punc_r  <= punc_nxt;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/uctf_queue.sv
// small queue of result groups between front and back
`default_nettype none

module uctf_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire uctf_pkg::ent_t push_ent,
  input  wire logic          pop,
  output uctf_pkg::ent_t     head,
  output logic               full,
  output logic               empty
);

  uctf_pkg::ent_t                    mem [uctf_pkg::QUEUE_DEPTH];
  logic [uctf_pkg::QPTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [uctf_pkg::QCNT_W-1:0]       count_r, count_nxt;

  assign full  = (count_r == uctf_pkg::QCNT_W'(uctf_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/uctf_back.sv
// back end: sends each group out one result word per clock while out_ready is high
`default_nettype none

module uctf_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire uctf_pkg::ent_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               out_byte_valid,
  output logic               out_has_chinese,
  output logic               out_has_punctuation,
  output logic               out_last
);

  logic       valid_r;
  logic [7:0] byte_r, byte_nxt;
  logic       bv_r, chin_r, punc_r, last_r;
  logic [1:0] idx_r;
  logic       load;
  logic       last_of;

  assign load    = !q_empty && (!valid_r || out_ready);
  assign last_of = (idx_r == (q_head.cnt - 2'd1));
  assign q_pop   = load && last_of;

  always_comb begin
    case (idx_r)
      2'd0:    byte_nxt = q_head.b0;
      2'd1:    byte_nxt = q_head.b1;
      default: byte_nxt = q_head.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (!valid_r || out_ready) begin
        valid_r <= !q_empty;
      end
      if (load) begin
        idx_r <= last_of ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  // flags only ride on the final word of a string
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      bv_r   <= !q_head.flag_only;
      last_r <= last_of && q_head.last;
      chin_r <= last_of && q_head.last && q_head.chin;
      punc_r <= last_of && q_head.last && q_head.punc;
    end
  end

  assign out_valid           = valid_r;
  assign out_byte            = byte_r;
  assign out_byte_valid      = bv_r;
  assign out_has_chinese     = chin_r;
  assign out_has_punctuation = punc_r;
  assign out_last            = last_r;

endmodule

`default_nettype wire

>>> rtl/utf8_cjk_text_filter.sv
// Filters a UTF-8 string that arrives one byte per word and gives the kept bytes
// one per result word, with the string's Chinese and punctuation flags on the
// final result. The input side takes one byte per clock; the classifier in the
// front end decides each byte combinationally and writes at most one group of
// one to three results into a four-entry queue. The output register sends one
// result per clock while out_ready is high, and the queue absorbs the bursts of
// kept three-byte sequences; input is held off only while the queue is full.
// A result passes through its queue entry and then the output register.
`default_nettype none

`include "utf8_cjk_text_filter_assert.svh"

module utf8_cjk_text_filter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_byte_valid,
  output logic            out_has_chinese,
  output logic            out_has_punctuation,
  output logic            out_last
);

  uctf_pkg::ent_t push_ent;
  uctf_pkg::ent_t q_head;
  logic           push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;

  uctf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_full   (q_full),
    .push     (push),
    .push_ent (push_ent)
  );

  uctf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  uctf_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_byte_valid      (out_byte_valid),
    .out_has_chinese     (out_has_chinese),
    .out_has_punctuation (out_has_punctuation),
    .out_last            (out_last)
  );

  `UCTF_ASSERT_NEVER(a_no_push_when_full, push && q_full, "push into full queue")
  `UCTF_ASSERT_NEVER(a_no_pop_when_empty, q_pop && q_empty, "pop from empty queue")
  `UCTF_ASSERT_IMP(a_flag_only_is_last, out_valid && !out_byte_valid, out_last && (out_byte == 8'h00), "flag-only word not final")
  `UCTF_ASSERT_IMP(a_flags_on_last, out_valid && (out_has_chinese || out_has_punctuation), out_last, "flags before final word")

endmodule

`default_nettype wire
